@@ design/round_robin_task_scheduler_macros.svh @@
// Assertion macros for the round-robin task scheduler checker.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define RRTS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rrts_pkg.sv @@
// Shared types and constants for the round-robin task scheduler.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package rrts_pkg;

   // Default size of the task table.
   localparam int MAX_TASKS_DEF = 16;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_YIELD  = 2'd1,
      OP_EXIT   = 2'd2,
      OP_WAIT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_READY   = 2'd0,
      MODE_WAITING = 2'd1,
      MODE_ZOMBIE  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_TASK = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // How the datapath builds the result item when the controller finishes.
   typedef enum logic [2:0] {
      FIN_NONE   = 3'd0,
      FIN_PLAIN  = 3'd1,
      FIN_NOTASK = 3'd2,
      FIN_REAP   = 3'd3,
      FIN_CREATE = 3'd4,
      FIN_SCHED  = 3'd5
   } fin_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_DECODE = 3'd1,
      S_CHECK  = 3'd2,
      S_ISSUE  = 3'd3,
      S_DRAIN  = 3'd4
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [3:0]         target_task;
      logic signed [31:0] exit_code;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [3:0]         created_task;
      logic [3:0]         running_now;
      logic               switched;
      logic signed [31:0] code_out;
      logic               reaped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load;
      logic    init_sweep;
      logic    read_target;
      logic    issue;
      fin_type fin;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   before_zero;
      logic   tgt_bad;
      logic   tgt_used;
      logic   tgt_zombie;
      logic   last;
   } sts_type;

endpackage

`default_nettype wire

@@ design/rrts_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
`default_nettype none

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/rrts_ctrl.sv @@
// Controller state machine of the round-robin task scheduler.
// Depends on rrts_pkg for the command, status, opcode and state types.
`default_nettype none

module rrts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrts_pkg::sts_type sts,
   output rrts_pkg::cmd_type cmd
);
   import rrts_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.fin  = FIN_NONE;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               OP_CREATE, OP_YIELD: begin
                  cmd.init_sweep = 1'b1;
                  state_in       = S_ISSUE;
               end
               OP_EXIT: begin
                  // The idle task never exits.
                  if (sts.before_zero) begin
                     cmd.fin  = FIN_PLAIN;
                     state_in = S_IDLE;
                  end else begin
                     cmd.init_sweep = 1'b1;
                     state_in       = S_ISSUE;
                  end
               end
               OP_WAIT: begin
                  if (sts.tgt_bad) begin
                     cmd.fin  = FIN_NOTASK;
                     state_in = S_IDLE;
                  end else begin
                     cmd.read_target = 1'b1;
                     state_in        = S_CHECK;
                  end
               end
               default: begin
                  cmd.fin  = FIN_PLAIN;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_CHECK: begin
            // Target entry is on the RAM output now.
            if (!sts.tgt_used) begin
               cmd.fin  = FIN_NOTASK;
               state_in = S_IDLE;
            end else if (sts.tgt_zombie) begin
               cmd.fin  = FIN_REAP;
               state_in = S_IDLE;
            end else begin
               cmd.init_sweep = 1'b1;
               state_in       = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            if (sts.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.fin  = (sts.op == OP_CREATE) ? FIN_CREATE : FIN_SCHED;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/rrts_dp.sv @@
// Datapath of the round-robin task scheduler: task table RAM, valid bits,
// sweep counters, per-slot update logic and the result register.
// Depends on rrts_pkg and rrts_ram.
`default_nettype none

module rrts_dp #(
   parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rrts_pkg::req_type req_item,
   input  rrts_pkg::cmd_type cmd,
   output rrts_pkg::sts_type sts,
   output logic              rsp_strobe,
   output rrts_pkg::rsp_type rsp_item
);
   import rrts_pkg::*;

   localparam int SLOT_W  = $clog2(MAX_TASKS);
   localparam int CNT_W   = SLOT_W + 1;
   localparam int CODE_W  = 32;
   localparam int WAIT_LO = 3;
   localparam int CODE_LO = WAIT_LO + SLOT_W;
   localparam int ENT_W   = CODE_LO + CODE_W;

   // Next slot with wrap at the table size.
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
      if (p == SLOT_W'(MAX_TASKS - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // Captured item and scheduler state.
   op_type            op_ff;
   logic [3:0]        target_ff;
   logic [CODE_W-1:0] code_ff;
   logic [SLOT_W-1:0] running_ff;
   logic [SLOT_W-1:0] running_in;

   // Sweep control and read pipeline.
   logic [SLOT_W-1:0] ptr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rd_vld_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic              ent_vld_ff;
   logic              found_ff;
   logic [SLOT_W-1:0] pick_ff;
   logic              valid_ff [MAX_TASKS];

   // RAM ports.
   logic [SLOT_W-1:0] rd_addr;
   logic [ENT_W-1:0]  ram_q;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [ENT_W-1:0]  wr_data;

   // Entry as read, with never-written entries at their reset value.
   logic              e_used;
   logic [1:0]        e_mode;
   logic [SLOT_W-1:0] e_wait;
   logic [CODE_W-1:0] e_code;

   // Per-slot evaluation.
   logic              is_cur;
   logic [1:0]        post_mode;
   logic [SLOT_W-1:0] post_wait;
   logic [CODE_W-1:0] post_code;
   logic              sched_wr;
   logic              ready_pick;
   logic              found_now_s;
   logic              found_now_c;
   logic              found_c;
   logic [SLOT_W-1:0] create_slot;
   logic [SLOT_W-1:0] pick_comb;

   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_strobe_ff;

   assign rd_addr = cmd.read_target ? SLOT_W'(target_ff) : ptr_ff;

   rrts_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Unpack the entry; an unwritten entry is free and ready, except slot 0.
   always_comb begin
      e_used = ent_vld_ff ? ram_q[0] : (rd_slot_ff == '0);
      e_mode = ent_vld_ff ? ram_q[2:1] : MODE_READY;
      e_wait = ent_vld_ff ? ram_q[WAIT_LO +: SLOT_W] : '0;
      e_code = ent_vld_ff ? ram_q[CODE_LO +: CODE_W] : '0;
   end

   // Scheduling sweep: apply the event to the running slot, wake waiters
   // on exit, and find the first ready task after the running slot.
   always_comb begin
      is_cur    = (rd_slot_ff == running_ff);
      post_mode = e_mode;
      post_wait = e_wait;
      post_code = e_code;
      sched_wr  = 1'b0;
      if (is_cur) begin
         if (op_ff == OP_EXIT) begin
            post_mode = MODE_ZOMBIE;
            post_code = code_ff;
            sched_wr  = 1'b1;
         end else if (op_ff == OP_WAIT) begin
            post_mode = MODE_WAITING;
            post_wait = SLOT_W'(target_ff);
            sched_wr  = 1'b1;
         end
      end else if (op_ff == OP_EXIT && e_used && e_mode == MODE_WAITING &&
                   e_wait == running_ff) begin
         post_mode = MODE_READY;
         post_wait = '0;
         sched_wr  = 1'b1;
      end
      ready_pick  = (rd_slot_ff != '0) && e_used && (post_mode == MODE_READY);
      found_now_s = rd_vld_ff && !found_ff && !is_cur && ready_pick;
      if (found_ff) begin
         pick_comb = pick_ff;
      end else if (found_now_s) begin
         pick_comb = rd_slot_ff;
      end else if (post_mode == MODE_READY) begin
         pick_comb = running_ff;
      end else begin
         pick_comb = '0;
      end
   end

   // Create sweep: the first free slot from 1 up.
   always_comb begin
      found_now_c = rd_vld_ff && !found_ff && !e_used;
      found_c     = found_ff || found_now_c;
      create_slot = found_ff ? pick_ff : rd_slot_ff;
   end

   // Table write: a reap clears the target, otherwise the sweep writes.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_slot_ff;
      wr_data = {post_code, post_wait, post_mode, e_used};
      if (cmd.fin == FIN_REAP) begin
         wr_en   = 1'b1;
         wr_addr = SLOT_W'(target_ff);
         wr_data = '0;
      end else if (rd_vld_ff && op_ff == OP_CREATE) begin
         wr_en   = found_now_c;
         wr_data = {{CODE_W{1'b0}}, {SLOT_W{1'b0}}, MODE_READY, 1'b1};
      end else if (rd_vld_ff) begin
         wr_en = sched_wr;
      end
   end

   // Result item built when the controller finishes.
   always_comb begin
      running_in          = running_ff;
      rsp_in.status       = ST_OK;
      rsp_in.created_task = '0;
      rsp_in.running_now  = 4'(running_ff);
      rsp_in.switched     = 1'b0;
      rsp_in.code_out     = '0;
      rsp_in.reaped       = 1'b0;
      case (cmd.fin)
         FIN_NOTASK: begin
            rsp_in.status = ST_NO_TASK;
         end
         FIN_REAP: begin
            rsp_in.code_out = e_code;
            rsp_in.reaped   = 1'b1;
         end
         FIN_CREATE: begin
            if (found_c) begin
               rsp_in.created_task = 4'(create_slot);
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         FIN_SCHED: begin
            running_in         = pick_comb;
            rsp_in.running_now = 4'(pick_comb);
            rsp_in.switched    = (pick_comb != running_ff);
         end
         default: begin
         end
      endcase
   end

   // Status back to the controller.
   always_comb begin
      sts.op          = op_ff;
      sts.before_zero = (running_ff == '0);
      sts.tgt_bad     = (int'(target_ff) >= MAX_TASKS);
      sts.tgt_used    = e_used;
      sts.tgt_zombie  = (e_mode == MODE_ZOMBIE);
      sts.last        = (cnt_ff == CNT_W'(1));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= '0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         rd_vld_ff     <= cmd.issue;
         rsp_strobe_ff <= (cmd.fin != FIN_NONE);
         running_ff    <= running_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.init_sweep) begin
            found_ff <= 1'b0;
            if (op_ff == OP_CREATE) begin
               cnt_ff <= CNT_W'(MAX_TASKS - 1);
            end else begin
               cnt_ff <= CNT_W'(MAX_TASKS);
            end
         end else if (cmd.issue) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (rd_vld_ff && ((op_ff == OP_CREATE) ? found_now_c : found_now_s)) begin
            found_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_item.op;
         target_ff <= req_item.target_task;
         code_ff   <= req_item.exit_code;
      end
      if (cmd.init_sweep) begin
         ptr_ff <= (op_ff == OP_CREATE) ? SLOT_W'(1) : next_slot(running_ff);
      end else if (cmd.issue) begin
         ptr_ff <= next_slot(ptr_ff);
      end
      if (rd_vld_ff && !found_ff) begin
         pick_ff <= rd_slot_ff;
      end
      rd_slot_ff <= rd_addr;
      ent_vld_ff <= valid_ff[rd_addr];
      if (cmd.fin != FIN_NONE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

@@ design/round_robin_task_scheduler.sv @@
// Round-robin task table scheduler. One item at a time: busy drops in the strobe cycle.
// Create, yield, a non-idle exit and a blocking wait sweep the table one slot per cycle.
// Synchronous reset frees every slot but the idle task, slot 0, which runs.
`default_nettype none

module round_robin_task_scheduler #(
   parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrts_pkg::req_type req_item,
   output logic              rsp_strobe,
   output rrts_pkg::rsp_type rsp_item
);
   import rrts_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rrts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   rrts_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

@@ design/rrts_checker.sv @@
// Port-level checker for the round-robin task scheduler, bound to the top.
// Depends on rrts_pkg and round_robin_task_scheduler_macros.svh.
`default_nettype none
`include "round_robin_task_scheduler_macros.svh"

module rrts_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input rrts_pkg::rsp_type rsp_item
);
   import rrts_pkg::*;

   // An accepted item keeps the block busy in the next cycle.
   `RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

   // Strobes never run back to back: a new item is decoded before its result is strobed.
   `RRTS_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe, "result strobe held two cycles")

   // A reap succeeds and never reschedules.
   `RRTS_ASSERT_IMPL(a_reap_ok, rsp_strobe && rsp_item.reaped, rsp_item.status == ST_OK && !rsp_item.switched, "reap with error or switch")

   // A failed event changes nothing.
   `RRTS_ASSERT_IMPL(a_err_quiet, rsp_strobe && rsp_item.status != ST_OK, !rsp_item.switched && !rsp_item.reaped && rsp_item.created_task == 4'd0, "failed event had effects")

endmodule

bind round_robin_task_scheduler rrts_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/tb_round_robin_task_scheduler.sv @@
// Self-checking testbench for the round-robin task scheduler: a directed table, then
// phases of random kernel events, each result checked against a behavioral scheduler.
// Depends on rrts_pkg and the round_robin_task_scheduler top level only.
module tb_round_robin_task_scheduler;
   import rrts_pkg::*;

   localparam int TASKS = MAX_TASKS_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int SETTLE_CYCLES = 2 * (TASKS + 2);
   localparam int RISKY_CAP = 3;
   localparam int DIR_ROWS = 17;
   localparam rsp_type NO_WANT = '0;

   typedef struct {
      op_type      op;
      logic [3:0]  tgt;
      logic [31:0] code;
      int          reps;
      bit          known;
      rsp_type     want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Behavioral copy of the task table.
   bit          task_live [TASKS];
   mode_type    task_state [TASKS];
   int          task_waits_on [TASKS];
   logic [31:0] task_code [TASKS];
   int          active_task;

   rsp_type     outcome_due [$];
   dir_row_type dir_table [DIR_ROWS];
   int          mismatches = 0;
   int          risky_waits = 0;
   int          cycle_count = 0;

   round_robin_task_scheduler #(.MAX_TASKS(TASKS)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Round-robin pick: first ready task after the running one, idle task excluded.
   function automatic void pick_next_task();
      int cur;
      int slot;
      int i;
      cur = active_task;
      for (i = 1; i < TASKS; i++) begin
         slot = (cur + i) % TASKS;
         if (slot != 0 && task_live[slot] && task_state[slot] == MODE_READY) begin
            active_task = slot;
            return;
         end
      end
      active_task = (task_state[cur] == MODE_READY) ? cur : 0;
   endfunction

   // Applies one event to the table and returns the result it produces.
   function automatic rsp_type schedule_event(req_type r);
      rsp_type outcome;
      int      prev;
      int      tgt;
      int      i;
      bit      found;
      outcome = '0;
      prev = active_task;
      found = 1'b0;
      case (r.op)
         OP_CREATE: begin
            for (i = 1; i < TASKS; i++) begin
               if (!found && !task_live[i]) begin
                  task_live[i] = 1'b1;
                  task_state[i] = MODE_READY;
                  task_waits_on[i] = 0;
                  task_code[i] = '0;
                  outcome.created_task = 4'(i);
                  found = 1'b1;
               end
            end
            if (!found) outcome.status = ST_FULL;
         end
         OP_YIELD: begin
            pick_next_task();
         end
         OP_EXIT: begin
            // The idle task never exits.
            if (prev != 0) begin
               for (i = 0; i < TASKS; i++) begin
                  if (task_live[i] && task_state[i] == MODE_WAITING &&
                      task_waits_on[i] == prev) begin
                     task_state[i] = MODE_READY;
                     task_waits_on[i] = 0;
                  end
               end
               task_code[prev] = r.exit_code;
               task_state[prev] = MODE_ZOMBIE;
               pick_next_task();
            end
         end
         default: begin
            tgt = r.target_task;
            if (tgt >= TASKS || !task_live[tgt]) begin
               outcome.status = ST_NO_TASK;
            end else if (task_state[tgt] == MODE_ZOMBIE) begin
               // Reaping frees the slot without a reschedule.
               outcome.code_out = task_code[tgt];
               outcome.reaped = 1'b1;
               task_live[tgt] = 1'b0;
               task_state[tgt] = MODE_READY;
               task_waits_on[tgt] = 0;
               task_code[tgt] = '0;
            end else begin
               task_state[prev] = MODE_WAITING;
               task_waits_on[prev] = tgt;
               pick_next_task();
            end
         end
      endcase
      outcome.running_now = 4'(active_task);
      outcome.switched = (active_task != prev);
      return outcome;
   endfunction

   // Builds a random event, mostly well formed so that tasks keep cycling through
   // create, wait, exit and reap instead of piling up blocked for ever.
   function automatic req_type next_event(int grow_pct);
      req_type r;
      int      zombies [$];
      int      others [$];
      int      i;
      int      t;
      for (i = 1; i < TASKS; i++) begin
         if (task_live[i] && task_state[i] == MODE_ZOMBIE) zombies.push_back(i);
         else if (task_live[i] && task_state[i] == MODE_READY && i != active_task)
            others.push_back(i);
      end
      r.target_task = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
         0: r.exit_code = 32'h8000_0000;
         1: r.exit_code = 32'h7fff_ffff;
         2: r.exit_code = '1;
         3: r.exit_code = '0;
         default: r.exit_code = $urandom;
      endcase
      if ($urandom_range(0, 99) < 8) begin
         // Noise: any event on any target. Waits that may block a task for good are
         // rationed, since nothing ever frees such a slot.
         r.op = op_type'($urandom_range(0, 3));
         t = r.target_task;
         if (r.op == OP_WAIT && active_task != 0 && task_live[t] &&
             task_state[t] != MODE_ZOMBIE &&
             (t == 0 || t == active_task || task_state[t] == MODE_WAITING)) begin
            if (risky_waits >= RISKY_CAP) r.op = OP_YIELD;
            else risky_waits++;
         end
      end else if ($urandom_range(0, 99) < grow_pct) begin
         r.op = OP_CREATE;
      end else begin
         r.op = OP_YIELD;
         case ($urandom_range(0, 3))
            1: if (active_task != 0) r.op = OP_EXIT;
            2: begin
               if (zombies.size() != 0) begin
                  r.op = OP_WAIT;
                  r.target_task = 4'(zombies[$urandom_range(0, zombies.size() - 1)]);
               end else if (others.size() != 0) begin
                  r.op = OP_WAIT;
                  r.target_task = 4'(others[$urandom_range(0, others.size() - 1)]);
               end
            end
            3: if (others.size() != 0) begin
               r.op = OP_WAIT;
               r.target_task = 4'(others[$urandom_range(0, others.size() - 1)]);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // Offers one item, holds it until accepted, then records what it must produce.
   task automatic send_item(input req_type r, input bit known, input rsp_type want);
      rsp_type forecast;
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      forecast = schedule_event(r);
      outcome_due.push_back(known ? want : forecast);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (outcome_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Each strobed result is matched against the oldest outstanding item.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outcome_due.size() == 0) begin
            $error("result with no item outstanding: running_now %0d", rsp_item.running_now);
            mismatches++;
         end else begin
            want = outcome_due.pop_front();
            check_field("status", want.status, rsp_item.status);
            check_field("created_task", want.created_task, rsp_item.created_task);
            check_field("running_now", want.running_now, rsp_item.running_now);
            check_field("switched", want.switched, rsp_item.switched);
            check_field("code_out", want.code_out, rsp_item.code_out);
            check_field("reaped", want.reaped, rsp_item.reaped);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_type item;
      int      row;
      int      rep;
      int      i;
      int      sent;
      int      phase_len;
      int      grow;
      int      burst_left;
      bit      bursty;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      for (i = 0; i < TASKS; i++) begin
         task_live[i] = (i == 0);
         task_state[i] = MODE_READY;
         task_waits_on[i] = 0;
         task_code[i] = '0;
      end
      active_task = 0;

      // Directed walk: idle-only table, errors, a wait and exit handshake, a task
      // blocking on itself, the idle task waiting, a full table and reaps.
      dir_table = '{
         '{OP_YIELD,  4'd0,  32'd0,          1, 1'b1, '{ST_OK, 4'd0, 4'd0, 1'b0, 32'd0, 1'b0}},
         '{OP_WAIT,   4'd7,  32'd0,          1, 1'b1,
           '{ST_NO_TASK, 4'd0, 4'd0, 1'b0, 32'd0, 1'b0}},
         '{OP_EXIT,   4'd0,  32'h7fff_ffff,  1, 1'b1, '{ST_OK, 4'd0, 4'd0, 1'b0, 32'd0, 1'b0}},
         '{OP_CREATE, 4'd0,  32'd0,          1, 1'b1, '{ST_OK, 4'd1, 4'd0, 1'b0, 32'd0, 1'b0}},
         '{OP_CREATE, 4'd0,  32'd0,          1, 1'b1, '{ST_OK, 4'd2, 4'd0, 1'b0, 32'd0, 1'b0}},
         '{OP_YIELD,  4'd0,  32'd0,          1, 1'b1, '{ST_OK, 4'd0, 4'd1, 1'b1, 32'd0, 1'b0}},
         '{OP_WAIT,   4'd2,  32'd0,          1, 1'b0, NO_WANT},
         '{OP_EXIT,   4'd0,  32'h8000_0000,  1, 1'b0, NO_WANT},
         '{OP_WAIT,   4'd2,  32'd0,          1, 1'b1,
           '{ST_OK, 4'd0, 4'd1, 1'b0, 32'h8000_0000, 1'b1}},
         '{OP_WAIT,   4'd1,  32'd0,          1, 1'b0, NO_WANT},
         '{OP_WAIT,   4'd0,  32'd0,          1, 1'b0, NO_WANT},
         '{OP_CREATE, 4'd0,  32'd0,          1, 1'b0, NO_WANT},
         '{OP_YIELD,  4'd15, 32'd0,          1, 1'b0, NO_WANT},
         '{OP_EXIT,   4'd0,  32'd0,          1, 1'b0, NO_WANT},
         '{OP_CREATE, 4'd0,  32'hffff_ffff, 13, 1'b0, NO_WANT},
         '{OP_CREATE, 4'd0,  32'd0,          1, 1'b1, '{ST_FULL, 4'd0, 4'd0, 1'b0, 32'd0, 1'b0}},
         '{OP_WAIT,   4'd2,  32'd0,          1, 1'b1, '{ST_OK, 4'd0, 4'd0, 1'b0, 32'd0, 1'b1}}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIR_ROWS; row++) begin
         for (rep = 0; rep < dir_table[row].reps; rep++) begin
            item.op = dir_table[row].op;
            item.target_task = dir_table[row].tgt;
            item.exit_code = dir_table[row].code;
            send_item(item, dir_table[row].known, dir_table[row].want);
         end
      end

      // Random phases, each with its own growth rate and sender behavior. Every phase
      // starts from a drained block.
      sent = 0;
      burst_left = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(80, 300);
         case ($urandom_range(0, 3))
            0: grow = 10;
            1: grow = 35;
            2: grow = 60;
            default: grow = 85;
         endcase
         bursty = ($urandom_range(0, 3) != 0);
         wait_drained();
         for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            if (bursty) begin
               if (burst_left == 0) begin
                  idle_cycles($urandom_range(1, 24));
                  burst_left = $urandom_range(1, 16);
               end
               burst_left--;
            end
            item = next_event(grow);
            // An exit by the idle task is ignored by the block.
            if (!(item.op == OP_EXIT && active_task == 0)) sent++;
            send_item(item, 1'b0, NO_WANT);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+design
design/rrts_pkg.sv
design/rrts_ram.sv
design/rrts_ctrl.sv
design/rrts_dp.sv
design/round_robin_task_scheduler.sv
design/rrts_checker.sv
tb/sv/tb_round_robin_task_scheduler.sv
